/* src/usm_pkg.sv */
// ----------------------------------------------------------------------------
// usm_pkg: shared definitions for the UV sphere mesh generator
// Widths, limits, the CORDIC arctangent table, sideband structs and the
// restoring-division step used by the quotient pipeline.
// ----------------------------------------------------------------------------
package usm_pkg;

	// limits applied to the count registers
	localparam int MAX_SECTORS     = 256;
	localparam int MAX_STACKS      = 256;
	localparam int MIN_SECTORS     = 3;
	localparam int MIN_STACKS      = 2;
	localparam int SECTORS_RST     = 36;
	localparam int STACKS_RST      = 18;
	localparam int COORD_FRAC_BITS = 15;

	// field widths
	localparam int CNT_W = 9;
	localparam int IDX_W = 9;
	localparam int VID_W = 17;
	localparam int TEX_W = 17;
	localparam int POS_W = 16;
	localparam int PH_W  = 32;

	// quotient pipeline: integer bit plus 33 fraction bits
	localparam int DIV_STEPS     = 34;
	localparam int DIV_PER_STAGE = 2;
	localparam int Q_W           = DIV_STEPS;

	// cordic datapath in Q30
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_FRAC  = 30;
	localparam int CS_W         = 32;
	localparam int Z_W          = 33;
	localparam logic signed [CS_W-1:0] CORDIC_START = 32'sd652032874;

	localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
		33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
		33'sd2670163, 33'sd1335087, 33'sd667544, 33'sd333772,
		33'sd166886, 33'sd83443, 33'sd41722, 33'sd20861,
		33'sd10430, 33'sd5215, 33'sd2608, 33'sd1304,
		33'sd652, 33'sd326, 33'sd163, 33'sd81,
		33'sd41, 33'sd20, 33'sd10, 33'sd5,
		33'sd3, 33'sd1
	};

	// configuration register indexes
	localparam logic REG_SECTORS = 1'b0;
	localparam logic REG_STACKS  = 1'b1;

	// record kinds
	localparam logic KIND_VERTEX   = 1'b0;
	localparam logic KIND_TRIANGLE = 1'b1;

	// triangle indices and which triangles the grid cell has
	typedef struct packed {
		logic [VID_W-1:0] k1;
		logic [VID_W-1:0] k2;
		logic             has_a;
		logic             has_b;
	} tri_t;

	// everything that rides alongside the trig datapath
	typedef struct packed {
		tri_t             faces;
		logic [TEX_W-1:0] tex_s;
		logic [TEX_W-1:0] tex_t;
	} side_t;

	// one restoring-division step result
	typedef struct packed {
		logic             q;
		logic [CNT_W-1:0] r;
	} dstep_t;

	// one quotient bit: optionally doubles the partial remainder first
	function automatic dstep_t div_step(input logic [CNT_W-1:0] r,
		input logic [CNT_W-1:0] d, input logic dbl);
		logic [CNT_W:0] t;
		dstep_t         o;
		t = dbl ? {r, 1'b0} : {1'b0, r};
		if (t >= {1'b0, d}) begin
			o.q = 1'b1;
			o.r = CNT_W'(t - {1'b0, d});
		end else begin
			o.q = 1'b0;
			o.r = t[CNT_W-1:0];
		end
		return o;
	endfunction

endpackage

/* src/uv_sphere_mesh_generator.sv */
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator: unit UV sphere tessellation, one grid point a beat
// Vertex position, texture coordinates and cell triangles per grid point.
// ----------------------------------------------------------------------------
// A grid point beat is taken every cycle unless pt_stall is high and comes
// out as one vertex record followed by zero, one or two triangle records,
// the last flagged by last. An accepted point passes one input register, 17
// divider stages (two quotient bits each), one phase stage, 32 CORDIC stages
// (fold, 30 rotations, unfold), a multiply stage, a rounding stage and the
// output register on its way to its vertex record. Throughput is set by the
// output port: a point holds it until its records, one to three, are out, and
// the pipeline holds while the triangle records of a point go out. Counts are
// clamped when written; writes should only land while nothing is in flight.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator #(
	parameter int MAX_SECTORS     = usm_pkg::MAX_SECTORS,
	parameter int MAX_STACKS      = usm_pkg::MAX_STACKS,
	parameter int COORD_FRAC_BITS = usm_pkg::COORD_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [usm_pkg::CNT_W-1:0]         cfg_data,
	// grid point channel
	input  logic                              pt_valid,
	output logic                              pt_stall,
	input  logic [usm_pkg::IDX_W-1:0]         stack_index,
	input  logic [usm_pkg::IDX_W-1:0]         sector_index,
	// record channel
	output logic                              rec_valid,
	input  logic                              rec_stall,
	output logic                              item_kind,
	output logic signed [usm_pkg::POS_W-1:0]  pos_x,
	output logic signed [usm_pkg::POS_W-1:0]  pos_y,
	output logic signed [usm_pkg::POS_W-1:0]  pos_z,
	output logic [usm_pkg::TEX_W-1:0]         tex_s,
	output logic [usm_pkg::TEX_W-1:0]         tex_t,
	output logic [usm_pkg::VID_W-1:0]         corner_a,
	output logic [usm_pkg::VID_W-1:0]         corner_b,
	output logic [usm_pkg::VID_W-1:0]         corner_c,
	output logic                              last
);

	localparam int K_W   = usm_pkg::IDX_W + usm_pkg::CNT_W + 1;
	localparam int TSH   = usm_pkg::Q_W - 1 - usm_pkg::TEX_W;
	localparam int RSH   = 2 * usm_pkg::CORDIC_FRAC - COORD_FRAC_BITS;
	localparam int P_W   = 2 * usm_pkg::CS_W;
	localparam logic [usm_pkg::PH_W-1:0] PH_QUARTER =
		usm_pkg::PH_W'(64'd1 << (usm_pkg::PH_W - 2));
	localparam logic signed [P_W-1:0] RND_HALF = P_W'(64'sd1 <<< (RSH - 1));
	localparam logic signed [P_W-1:0] POS_MAX  =
		P_W'((64'sd1 <<< (usm_pkg::POS_W - 1)) - 64'sd1);
	localparam logic signed [P_W-1:0] POS_MIN  =
		P_W'(-(64'sd1 <<< (usm_pkg::POS_W - 1)));

	// Q60 product to saturated coordinate, rounded half up
	function automatic logic signed [usm_pkg::POS_W-1:0] to_coord(
		input logic signed [P_W-1:0] p);
		logic signed [P_W-1:0] t;
		t = (p + RND_HALF) >>> RSH;
		if (t > POS_MAX) begin
			return POS_MAX[usm_pkg::POS_W-1:0];
		end else if (t < POS_MIN) begin
			return POS_MIN[usm_pkg::POS_W-1:0];
		end
		return t[usm_pkg::POS_W-1:0];
	endfunction

	logic                              adv;
	logic [usm_pkg::CNT_W-1:0]         sec_q;
	logic [usm_pkg::CNT_W-1:0]         stk_q;

	logic                              vld_s1;
	logic [usm_pkg::IDX_W-1:0]         i_s1;
	logic [usm_pkg::IDX_W-1:0]         j_s1;

	logic [usm_pkg::CNT_W:0]           sec_p1;
	logic [K_W-1:0]                    k1_w;
	logic                              grid;
	usm_pkg::tri_t                     faces_w;

	logic                              div_vld;
	logic [usm_pkg::Q_W-1:0]           div_qi;
	logic [usm_pkg::Q_W-1:0]           div_qj;
	usm_pkg::tri_t                     div_faces;

	logic [usm_pkg::Q_W:0]             lon_r;
	logic [usm_pkg::Q_W-1:0]           lat_r;
	logic [usm_pkg::Q_W-TSH:0]         ts_r;
	logic [usm_pkg::Q_W-TSH:0]         tt_r;

	logic                              vld_s2;
	logic [usm_pkg::PH_W-1:0]          lat_s2;
	logic [usm_pkg::PH_W-1:0]          lon_s2;
	usm_pkg::side_t                    side_s2;

	logic                              cor_vld;
	logic signed [usm_pkg::CS_W-1:0]   clat, slat, clon, slon;
	usm_pkg::side_t                    cor_side;

	logic                              vld_s3;
	logic signed [P_W-1:0]             px_s3, py_s3, pz_s3;
	usm_pkg::side_t                    side_s3;

	logic                              vld_s4;
	logic signed [usm_pkg::POS_W-1:0]  x_s4, y_s4, z_s4;
	usm_pkg::side_t                    side_s4;

	// count registers, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= usm_pkg::CNT_W'(usm_pkg::SECTORS_RST);
			stk_q <= usm_pkg::CNT_W'(usm_pkg::STACKS_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				usm_pkg::REG_SECTORS: begin
					if (int'(cfg_data) < usm_pkg::MIN_SECTORS) begin
						sec_q <= usm_pkg::CNT_W'(usm_pkg::MIN_SECTORS);
					end else if (int'(cfg_data) > MAX_SECTORS) begin
						sec_q <= usm_pkg::CNT_W'(MAX_SECTORS);
					end else begin
						sec_q <= cfg_data;
					end
				end
				usm_pkg::REG_STACKS: begin
					if (int'(cfg_data) < usm_pkg::MIN_STACKS) begin
						stk_q <= usm_pkg::CNT_W'(usm_pkg::MIN_STACKS);
					end else if (int'(cfg_data) > MAX_STACKS) begin
						stk_q <= usm_pkg::CNT_W'(MAX_STACKS);
					end else begin
						stk_q <= cfg_data;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign pt_stall = !adv;

	// input register, indices saturated to the counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			i_s1 <= (stack_index > stk_q) ? stk_q : stack_index;
			j_s1 <= (sector_index > sec_q) ? sec_q : sector_index;
		end
	end

	// vertex numbering and which triangles the cell owns
	assign sec_p1 = {1'b0, sec_q} + 1'b1;
	assign k1_w   = K_W'(i_s1) * K_W'(sec_p1) + K_W'(j_s1);
	assign grid   = (i_s1 < stk_q) && (j_s1 < sec_q);

	always_comb begin
		faces_w.k1    = k1_w[usm_pkg::VID_W-1:0];
		faces_w.k2    = k1_w[usm_pkg::VID_W-1:0] + usm_pkg::VID_W'(sec_p1);
		faces_w.has_a = grid && (i_s1 != '0);
		faces_w.has_b = grid && (i_s1 != stk_q - 1'b1);
	end

	usm_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.head_vld   (vld_s1),
		.head_i     (i_s1),
		.head_j     (j_s1),
		.head_faces (faces_w),
		.sec        (sec_q),
		.stk        (stk_q),
		.tail_vld   (div_vld),
		.tail_qi    (div_qi),
		.tail_qj    (div_qj),
		.tail_faces (div_faces)
	);

	// phases and texture coordinates from the quotients, rounded half up
	assign lon_r = {1'b0, div_qj} + 1'b1;
	assign lat_r = {1'b0, div_qi[usm_pkg::Q_W-1:1]} + 1'b1;
	assign ts_r  = {1'b0, div_qj[usm_pkg::Q_W-1:TSH]} + 1'b1;
	assign tt_r  = {1'b0, div_qi[usm_pkg::Q_W-1:TSH]} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lon_s2        <= lon_r[usm_pkg::PH_W:1];
			lat_s2        <= PH_QUARTER - lat_r[usm_pkg::PH_W:1];
			side_s2.faces <= div_faces;
			side_s2.tex_s <= ts_r[usm_pkg::TEX_W:1];
			side_s2.tex_t <= tt_r[usm_pkg::TEX_W:1];
		end
	end

	usm_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.head_vld  (vld_s2),
		.head_lat  (lat_s2),
		.head_lon  (lon_s2),
		.head_side (side_s2),
		.tail_vld  (cor_vld),
		.tail_clat (clat),
		.tail_slat (slat),
		.tail_clon (clon),
		.tail_slon (slon),
		.tail_side (cor_side)
	);

	// Q60 products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= cor_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s3   <= P_W'(clat) * P_W'(clon);
			py_s3   <= P_W'(clat) * P_W'(slon);
			pz_s3   <= P_W'(slat) <<< usm_pkg::CORDIC_FRAC;
			side_s3 <= cor_side;
		end
	end

	// round and saturate to the coordinate format
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s4    <= to_coord(px_s3);
			y_s4    <= to_coord(py_s3);
			z_s4    <= to_coord(pz_s3);
			side_s4 <= side_s3;
		end
	end

	usm_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_vld  (vld_s4),
		.head_x    (x_s4),
		.head_y    (y_s4),
		.head_z    (z_s4),
		.head_side (side_s4),
		.adv       (adv),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.item_kind (item_kind),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.tex_s     (tex_s),
		.tex_t     (tex_t),
		.corner_a  (corner_a),
		.corner_b  (corner_b),
		.corner_c  (corner_c),
		.last      (last)
	);

endmodule

/* src/usm_div.sv */
// ----------------------------------------------------------------------------
// usm_div: pipelined fractional divider
// Forms floor(i * 2^33 / stk) and floor(j * 2^33 / sec) side by side, a few
// restoring steps per stage, with the triangle sideband travelling along.
// ----------------------------------------------------------------------------
module usm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          head_vld,
	input  logic [usm_pkg::IDX_W-1:0]     head_i,
	input  logic [usm_pkg::IDX_W-1:0]     head_j,
	input  usm_pkg::tri_t                 head_faces,
	input  logic [usm_pkg::CNT_W-1:0]     sec,
	input  logic [usm_pkg::CNT_W-1:0]     stk,
	output logic                          tail_vld,
	output logic [usm_pkg::Q_W-1:0]       tail_qi,
	output logic [usm_pkg::Q_W-1:0]       tail_qj,
	output usm_pkg::tri_t                 tail_faces
);

	localparam int NST = (usm_pkg::DIV_STEPS + usm_pkg::DIV_PER_STAGE - 1)
		/ usm_pkg::DIV_PER_STAGE;

	logic                        vld_s   [NST];
	logic [usm_pkg::CNT_W-1:0]   ri_s    [NST];
	logic [usm_pkg::CNT_W-1:0]   rj_s    [NST];
	logic [usm_pkg::Q_W-1:0]     qi_s    [NST];
	logic [usm_pkg::Q_W-1:0]     qj_s    [NST];
	usm_pkg::tri_t               faces_s [NST];

	for (genvar s = 0; s < NST; s++) begin : g_st
		logic                      v_a;
		logic [usm_pkg::CNT_W-1:0] ri_a, rj_a, ri_n, rj_n;
		logic [usm_pkg::Q_W-1:0]   qi_a, qj_a, qi_n, qj_n;
		usm_pkg::tri_t             f_a;

		// stage source: the input port or the previous stage
		if (s == 0) begin : g_src
			assign v_a  = head_vld;
			assign ri_a = usm_pkg::CNT_W'(head_i);
			assign rj_a = usm_pkg::CNT_W'(head_j);
			assign qi_a = '0;
			assign qj_a = '0;
			assign f_a  = head_faces;
		end else begin : g_src
			assign v_a  = vld_s[s-1];
			assign ri_a = ri_s[s-1];
			assign rj_a = rj_s[s-1];
			assign qi_a = qi_s[s-1];
			assign qj_a = qj_s[s-1];
			assign f_a  = faces_s[s-1];
		end

		// quotient bits of this stage, first step has no doubling
		always_comb begin : c_step
			usm_pkg::dstep_t di, dj;
			ri_n = ri_a;
			rj_n = rj_a;
			qi_n = qi_a;
			qj_n = qj_a;
			for (int m = 0; m < usm_pkg::DIV_PER_STAGE; m++) begin
				if (s * usm_pkg::DIV_PER_STAGE + m < usm_pkg::DIV_STEPS) begin
					di = usm_pkg::div_step(ri_n, stk, (s * usm_pkg::DIV_PER_STAGE + m) != 0);
					dj = usm_pkg::div_step(rj_n, sec, (s * usm_pkg::DIV_PER_STAGE + m) != 0);
					ri_n = di.r;
					rj_n = dj.r;
					qi_n = {qi_n[usm_pkg::Q_W-2:0], di.q};
					qj_n = {qj_n[usm_pkg::Q_W-2:0], dj.q};
				end
			end
		end

		// valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (en) begin
				vld_s[s] <= v_a;
			end
		end

		// payload
		always_ff @(posedge clk) begin
			if (en) begin
				ri_s[s]    <= ri_n;
				rj_s[s]    <= rj_n;
				qi_s[s]    <= qi_n;
				qj_s[s]    <= qj_n;
				faces_s[s] <= f_a;
			end
		end
	end

	assign tail_vld   = vld_s[NST-1];
	assign tail_qi    = qi_s[NST-1];
	assign tail_qj    = qj_s[NST-1];
	assign tail_faces = faces_s[NST-1];

endmodule

/* src/usm_cordic.sv */
// ----------------------------------------------------------------------------
// usm_cordic: pipelined sine and cosine for two phases
// Folds each phase into a quarter turn either side of zero, runs one CORDIC
// rotation per stage, then undoes the fold. Results in Q30.
// ----------------------------------------------------------------------------
module usm_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              head_vld,
	input  logic [usm_pkg::PH_W-1:0]          head_lat,
	input  logic [usm_pkg::PH_W-1:0]          head_lon,
	input  usm_pkg::side_t                    head_side,
	output logic                              tail_vld,
	output logic signed [usm_pkg::CS_W-1:0]   tail_clat,
	output logic signed [usm_pkg::CS_W-1:0]   tail_slat,
	output logic signed [usm_pkg::CS_W-1:0]   tail_clon,
	output logic signed [usm_pkg::CS_W-1:0]   tail_slon,
	output usm_pkg::side_t                    tail_side
);

	localparam int NST = usm_pkg::CORDIC_STEPS + 2;
	localparam logic signed [usm_pkg::Z_W-1:0] PH_QUARTER =
		usm_pkg::Z_W'(64'sd1 <<< (usm_pkg::PH_W - 2));
	localparam logic signed [usm_pkg::Z_W-1:0] PH_HALF =
		usm_pkg::Z_W'(64'sd1 <<< (usm_pkg::PH_W - 1));

	typedef struct packed {
		logic signed [usm_pkg::CS_W-1:0] x;
		logic signed [usm_pkg::CS_W-1:0] y;
		logic signed [usm_pkg::Z_W-1:0]  z;
		logic                            flip;
	} lane_t;

	// phase to signed angle, folded into a quarter turn either side of zero
	function automatic lane_t fold(input logic [usm_pkg::PH_W-1:0] ph);
		lane_t                          o;
		logic signed [usm_pkg::Z_W-1:0] z;
		z      = {ph[usm_pkg::PH_W-1], ph};
		o.x    = usm_pkg::CORDIC_START;
		o.y    = '0;
		o.z    = z;
		o.flip = 1'b0;
		if (z > PH_QUARTER) begin
			o.z    = z - PH_HALF;
			o.flip = 1'b1;
		end else if (z < -PH_QUARTER) begin
			o.z    = z + PH_HALF;
			o.flip = 1'b1;
		end
		return o;
	endfunction

	// one rotation towards zero residual angle
	function automatic lane_t rot(input lane_t a, input int k);
		lane_t o;
		o = a;
		if (a.z >= 0) begin
			o.x = a.x - (a.y >>> k);
			o.y = a.y + (a.x >>> k);
			o.z = a.z - usm_pkg::ATAN_TAB[k];
		end else begin
			o.x = a.x + (a.y >>> k);
			o.y = a.y - (a.x >>> k);
			o.z = a.z + usm_pkg::ATAN_TAB[k];
		end
		return o;
	endfunction

	// half-turn correction for folded angles
	function automatic lane_t unfold(input lane_t a);
		lane_t o;
		o = a;
		if (a.flip) begin
			o.x = -a.x;
			o.y = -a.y;
		end
		return o;
	endfunction

	logic           vld_s  [NST];
	lane_t          lat_s  [NST];
	lane_t          lon_s  [NST];
	usm_pkg::side_t side_s [NST];

	for (genvar s = 0; s < NST; s++) begin : g_st
		logic           v_n;
		lane_t          lat_n, lon_n;
		usm_pkg::side_t side_n;

		if (s == 0) begin : g_fn
			always_comb begin
				v_n    = head_vld;
				lat_n  = fold(head_lat);
				lon_n  = fold(head_lon);
				side_n = head_side;
			end
		end else if (s <= usm_pkg::CORDIC_STEPS) begin : g_fn
			always_comb begin
				v_n    = vld_s[s-1];
				lat_n  = rot(lat_s[s-1], s - 1);
				lon_n  = rot(lon_s[s-1], s - 1);
				side_n = side_s[s-1];
			end
		end else begin : g_fn
			always_comb begin
				v_n    = vld_s[s-1];
				lat_n  = unfold(lat_s[s-1]);
				lon_n  = unfold(lon_s[s-1]);
				side_n = side_s[s-1];
			end
		end

		// valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (en) begin
				vld_s[s] <= v_n;
			end
		end

		// payload
		always_ff @(posedge clk) begin
			if (en) begin
				lat_s[s]  <= lat_n;
				lon_s[s]  <= lon_n;
				side_s[s] <= side_n;
			end
		end
	end

	assign tail_vld  = vld_s[NST-1];
	assign tail_clat = lat_s[NST-1].x;
	assign tail_slat = lat_s[NST-1].y;
	assign tail_clon = lon_s[NST-1].x;
	assign tail_slon = lon_s[NST-1].y;
	assign tail_side = side_s[NST-1];

endmodule

/* src/usm_emit.sv */
// ----------------------------------------------------------------------------
// usm_emit: record sequencer at the output
// Turns one finished grid point into a vertex record and up to two triangle
// records, holding the pipeline while the extra records go out.
// ----------------------------------------------------------------------------
module usm_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_vld,
	input  logic signed [usm_pkg::POS_W-1:0]  head_x,
	input  logic signed [usm_pkg::POS_W-1:0]  head_y,
	input  logic signed [usm_pkg::POS_W-1:0]  head_z,
	input  usm_pkg::side_t                    head_side,
	output logic                              adv,
	output logic                              rec_valid,
	input  logic                              rec_stall,
	output logic                              item_kind,
	output logic signed [usm_pkg::POS_W-1:0]  pos_x,
	output logic signed [usm_pkg::POS_W-1:0]  pos_y,
	output logic signed [usm_pkg::POS_W-1:0]  pos_z,
	output logic [usm_pkg::TEX_W-1:0]         tex_s,
	output logic [usm_pkg::TEX_W-1:0]         tex_t,
	output logic [usm_pkg::VID_W-1:0]         corner_a,
	output logic [usm_pkg::VID_W-1:0]         corner_b,
	output logic [usm_pkg::VID_W-1:0]         corner_c,
	output logic                              last
);

	typedef enum logic [1:0] {
		ST_VTX,
		ST_TRI_A,
		ST_TRI_B
	} step_t;

	step_t                     step_q;
	usm_pkg::tri_t             faces_q;
	logic                      slot_free;
	logic                      more;
	logic [usm_pkg::VID_W-1:0] k1_inc;
	logic [usm_pkg::VID_W-1:0] k2_inc;

	// output slot frees when empty or its beat is taken
	assign slot_free = !rec_valid || !rec_stall;
	assign more      = rec_valid && !last;
	assign adv       = slot_free && !more;

	assign k1_inc = faces_q.k1 + 1'b1;
	assign k2_inc = faces_q.k2 + 1'b1;

	// record sequencing and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid <= 1'b0;
			step_q    <= ST_VTX;
		end else if (slot_free) begin
			if (more) begin
				item_kind <= usm_pkg::KIND_TRIANGLE;
				pos_x     <= '0;
				pos_y     <= '0;
				pos_z     <= '0;
				tex_s     <= '0;
				tex_t     <= '0;
				unique case (step_q)
					ST_VTX: begin
						if (faces_q.has_a) begin
							step_q   <= ST_TRI_A;
							corner_a <= faces_q.k1;
							corner_b <= faces_q.k2;
							corner_c <= k1_inc;
							last     <= !faces_q.has_b;
						end else begin
							step_q   <= ST_TRI_B;
							corner_a <= k1_inc;
							corner_b <= faces_q.k2;
							corner_c <= k2_inc;
							last     <= 1'b1;
						end
					end
					default: begin
						step_q   <= ST_TRI_B;
						corner_a <= k1_inc;
						corner_b <= faces_q.k2;
						corner_c <= k2_inc;
						last     <= 1'b1;
					end
				endcase
			end else if (head_vld) begin
				rec_valid <= 1'b1;
				step_q    <= ST_VTX;
				faces_q   <= head_side.faces;
				item_kind <= usm_pkg::KIND_VERTEX;
				pos_x     <= head_x;
				pos_y     <= head_y;
				pos_z     <= head_z;
				tex_s     <= head_side.tex_s;
				tex_t     <= head_side.tex_t;
				corner_a  <= '0;
				corner_b  <= '0;
				corner_c  <= '0;
				last      <= !head_side.faces.has_a && !head_side.faces.has_b;
			end else begin
				rec_valid <= 1'b0;
			end
		end
	end

endmodule

/* verif/tb_uv_sphere_mesh_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uv_sphere_mesh_generator: self-checking bench for the UV sphere generator
// Grid point beats go in under random and directed counts. Each accepted
// point is turned into its expected vertex and triangle records by an
// integer CORDIC predictor, and the record channel is checked in order.
// ----------------------------------------------------------------------------
module tb_uv_sphere_mesh_generator;
	import usm_pkg::*;

	// one record as seen on the output channel
	typedef struct packed {
		logic                    kind;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [TEX_W-1:0]        s;
		logic [TEX_W-1:0]        t;
		logic [VID_W-1:0]        a;
		logic [VID_W-1:0]        b;
		logic [VID_W-1:0]        c;
		logic                    lst;
	} mesh_rec_t;

	// expected mesh records and the sphere arithmetic behind them
	class mesh_scoreboard;
		mesh_rec_t   pending_recs[$];
		int unsigned sectors = SECTORS_RST;
		int unsigned stacks  = STACKS_RST;
		int          mismatches;
		int          points_seen;
		int          recs_seen;
		int          tris_seen;

		function void set_count(logic idx, logic [CNT_W-1:0] val);
			if (idx == REG_SECTORS)
				sectors = val;
			else
				stacks = val;
		endfunction

		// rotation-mode cordic on a phase in 2^-32 turn, results in Q30
		function void sin_cos(longint unsigned ph, output longint co, output longint si);
			longint z, x, y, nx;
			bit     flip;
			z = longint'(ph);
			x = longint'(CORDIC_START);
			y = 0;
			flip = 0;
			if (z >= (64'sd1 <<< 31))
				z -= (64'sd1 <<< 32);
			if (z > (64'sd1 <<< 30)) begin
				z -= (64'sd1 <<< 31);
				flip = 1;
			end else if (z < -(64'sd1 <<< 30)) begin
				z += (64'sd1 <<< 31);
				flip = 1;
			end
			for (int k = 0; k < CORDIC_STEPS; k++) begin
				if (z >= 0) begin
					nx = x - (y >>> k);
					y  = y + (x >>> k);
					z -= longint'(ATAN_TAB[k]);
				end else begin
					nx = x + (y >>> k);
					y  = y - (x >>> k);
					z += longint'(ATAN_TAB[k]);
				end
				x = nx;
			end
			co = flip ? -x : x;
			si = flip ? -y : y;
		endfunction

		// Q60 product to Q1.15, round half up and saturate
		function logic signed [POS_W-1:0] to_coord(longint p);
			longint v;
			v = (p + (64'sd1 <<< (59 - COORD_FRAC_BITS))) >>> (60 - COORD_FRAC_BITS);
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			return POS_W'(v);
		endfunction

		// accepted grid point: queue its vertex and triangles
		function void note_point(logic [IDX_W-1:0] si, logic [IDX_W-1:0] sj);
			longint unsigned sec, stk, i, j, lon, lat, k1, k2;
			longint          clat, slat, clon, slon;
			mesh_rec_t       r;
			sec = sectors < MIN_SECTORS ? MIN_SECTORS : (sectors > MAX_SECTORS ? MAX_SECTORS : sectors);
			stk = stacks < MIN_STACKS ? MIN_STACKS : (stacks > MAX_STACKS ? MAX_STACKS : stacks);
			i = si > stk ? stk : si;
			j = sj > sec ? sec : sj;
			lon = (((j << 32) + sec / 2) / sec) & 64'hFFFF_FFFF;
			lat = ((64'd1 << 30) - (((i << 31) + stk / 2) / stk)) & 64'hFFFF_FFFF;
			sin_cos(lat, clat, slat);
			sin_cos(lon, clon, slon);
			r = '0;
			r.kind = KIND_VERTEX;
			r.x = to_coord(clat * clon);
			r.y = to_coord(clat * slon);
			r.z = to_coord(slat * (64'sd1 <<< 30));
			r.s = TEX_W'((j * 65536 + sec / 2) / sec);
			r.t = TEX_W'((i * 65536 + stk / 2) / stk);
			pending_recs.push_back(r);
			if (i < stk && j < sec) begin
				k1 = i * (sec + 1) + j;
				k2 = k1 + sec + 1;
				if (i != 0) begin
					r = '0;
					r.kind = KIND_TRIANGLE;
					r.a = VID_W'(k1);
					r.b = VID_W'(k2);
					r.c = VID_W'(k1 + 1);
					pending_recs.push_back(r);
				end
				if (i != stk - 1) begin
					r = '0;
					r.kind = KIND_TRIANGLE;
					r.a = VID_W'(k1 + 1);
					r.b = VID_W'(k2);
					r.c = VID_W'(k2 + 1);
					pending_recs.push_back(r);
				end
			end
			pending_recs[$].lst = 1'b1;
			points_seen++;
		endfunction

		// record beat against the oldest expectation
		function void check_rec(mesh_rec_t got);
			mesh_rec_t exp_r;
			recs_seen++;
			if (pending_recs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected record %p", $realtime, got);
				return;
			end
			exp_r = pending_recs.pop_front();
			if (exp_r.kind == KIND_TRIANGLE)
				tris_seen++;
			if (got.kind != exp_r.kind || got.x != exp_r.x || got.y != exp_r.y ||
					got.z != exp_r.z || got.s != exp_r.s || got.t != exp_r.t ||
					got.a != exp_r.a || got.b != exp_r.b || got.c != exp_r.c ||
					got.lst != exp_r.lst) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: record mismatch (sectors %0d stacks %0d)", $realtime,
						sectors, stacks);
					$display("  expected kind %0d pos %0d %0d %0d tex %0d %0d tri %0d %0d %0d last %0d",
						exp_r.kind, exp_r.x, exp_r.y, exp_r.z, exp_r.s, exp_r.t,
						exp_r.a, exp_r.b, exp_r.c, exp_r.lst);
					$display("  actual   kind %0d pos %0d %0d %0d tex %0d %0d tri %0d %0d %0d last %0d",
						got.kind, got.x, got.y, got.z, got.s, got.t,
						got.a, got.b, got.c, got.lst);
				end
			end
		endfunction
	endclass

	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic                    cfg_index;
	logic [CNT_W-1:0]        cfg_data;
	logic                    pt_valid;
	logic                    pt_stall;
	logic [IDX_W-1:0]        stack_index;
	logic [IDX_W-1:0]        sector_index;
	logic                    rec_valid;
	logic                    rec_stall;
	logic                    item_kind;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic [TEX_W-1:0]        tex_s, tex_t;
	logic [VID_W-1:0]        corner_a, corner_b, corner_c;
	logic                    last;

	mesh_scoreboard sb = new();
	int             tx_idle_pct;
	int             rx_idle_pct;
	logic           rx_hold;
	bit             hold_go;
	int unsigned    cycles;

	uv_sphere_mesh_generator dut (.*);

	// clock
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d records outstanding", cycles,
				sb.pending_recs.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// long receiver hold-off, counted here
	initial begin
		rx_hold = 0;
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 0;
	end

	// record side: check each accepted beat, then pick the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_stall <= 1'b0;
		end else begin
			if (rec_valid && !rec_stall)
				sb.check_rec({item_kind, pos_x, pos_y, pos_z, tex_s, tex_t,
					corner_a, corner_b, corner_c, last});
			rec_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// one grid point beat, held until taken
	task automatic send_point(logic [IDX_W-1:0] i, logic [IDX_W-1:0] j);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			pt_valid <= 1'b0;
			@(posedge clk);
		end
		pt_valid     <= 1'b1;
		stack_index  <= i;
		sector_index <= j;
		do
			@(posedge clk);
		while (pt_stall);
		sb.note_point(i, j);
	endtask

	// wait for every record, then let the pipe empty
	task automatic drain();
		pt_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_recs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// count register write while the block is idle
	task automatic write_count(logic idx, logic [CNT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_count(idx, val);
	endtask

	// random points, mostly on the grid, some anywhere in the field range
	task automatic random_points(int n);
		int unsigned sec, stk;
		sec = sb.sectors < MIN_SECTORS ? MIN_SECTORS :
			(sb.sectors > MAX_SECTORS ? MAX_SECTORS : sb.sectors);
		stk = sb.stacks < MIN_STACKS ? MIN_STACKS :
			(sb.stacks > MAX_STACKS ? MAX_STACKS : sb.stacks);
		repeat (n) begin
			if ($urandom_range(0, 99) < 80)
				send_point(IDX_W'($urandom_range(0, stk)), IDX_W'($urandom_range(0, sec)));
			else
				send_point(IDX_W'($urandom), IDX_W'($urandom));
		end
	endtask

	initial begin
		arst_n       = 0;
		cfg_we       = 0;
		cfg_index    = REG_SECTORS;
		cfg_data     = '0;
		pt_valid     = 0;
		stack_index  = '0;
		sector_index = '0;
		hold_go      = 0;
		cycles       = 0;
		tx_idle_pct  = 7;
		rx_idle_pct  = 46;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: poles, seams, grid edges, saturated indices at reset counts
		send_point(0, 0);
		send_point(0, 35);
		send_point(1, 0);
		send_point(17, 0);
		send_point(17, 35);
		send_point(18, 0);
		send_point(18, 36);
		send_point(0, 36);
		send_point(9, 18);
		send_point(9'h1FF, 9'h1FF);
		send_point(300, 5);
		send_point(5, 300);
		drain();

		// smallest grid
		write_count(REG_SECTORS, 3);
		write_count(REG_STACKS, 2);
		send_point(0, 0);
		send_point(1, 2);
		send_point(2, 3);
		send_point(1, 0);
		random_points(50);
		drain();

		// largest grid with a long receiver hold-off while points keep coming
		write_count(REG_SECTORS, 256);
		write_count(REG_STACKS, 256);
		send_point(255, 255);
		send_point(256, 256);
		send_point(0, 255);
		hold_go = 1;
		random_points(60);
		drain();

		// out of range counts, clamped by the block
		tx_idle_pct = 46;
		rx_idle_pct = 7;
		write_count(REG_SECTORS, 0);
		write_count(REG_STACKS, 9'h1FF);
		random_points(50);
		drain();
		write_count(REG_SECTORS, 9'h1FF);
		write_count(REG_STACKS, 1);
		random_points(50);
		drain();

		// random counts, back-to-back traffic
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (3) begin
			write_count(REG_SECTORS, CNT_W'($urandom_range(3, 256)));
			write_count(REG_STACKS, CNT_W'($urandom_range(2, 256)));
			random_points(50);
			drain();
		end

		$display("covered %0d grid points, %0d records (%0d triangles) over several grid sizes",
			sb.points_seen, sb.recs_seen, sb.tris_seen);
		if (sb.mismatches == 0 && sb.pending_recs.size() == 0)
			$display("Regression PASS");
		else begin
			$display("%0d mismatches, %0d records missing", sb.mismatches,
				sb.pending_recs.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
